// ----- rtl/deq_pkg.sv -----
// Package for the double-ended queue: ring depth, pointer and count widths,
// operation and status codes, item/result structs and controller command bundle.
// No dependencies.
package deq_pkg;

	localparam int DEPTH = 16;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CHAR_W = 8;

	typedef enum logic [1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_POP_BACK   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [CHAR_W-1:0] char_in;
	} deq_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] front_char;
		logic [CHAR_W-1:0] back_char;
		logic              is_empty;
		logic              is_full;
		logic [1:0]        status;
	} deq_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture the accepted beat
		logic exec;   // update pointers, count, write the ring
		logic read;   // fetch front and back slots
	} deq_cmd_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
	endfunction

endpackage

// ----- rtl/deq_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr_a,
	input  logic [AW-1:0]        raddr_b,
	output logic [WIDTH-1:0]     rdata_a,
	output logic [WIDTH-1:0]     rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ----- rtl/deq_ctrl.sv -----
// Controller for the double-ended queue: sequences exec, read and result beat.
// Depends on deq_pkg.
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output deq_pkg::deq_cmd_t cmd
);
	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_DONE} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q == S_EXEC) || (state_q == S_READ);
	assign accept = start && !busy;
	assign done   = done_q;

	assign cmd.load = accept;
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.read = (state_q == S_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE, S_DONE: begin
					state_q <= accept ? S_EXEC : S_IDLE;
				end
				S_EXEC: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_DONE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/deq_dpath.sv -----
// Datapath for the double-ended queue: head/tail pointers, count, status and
// the ring store. Depends on deq_pkg and deq_ram.
module deq_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  deq_pkg::deq_cmd_t cmd,
	input  deq_pkg::deq_in_t  item,
	output deq_pkg::deq_out_t result
);
	logic [1:0]                  func_q;
	logic [deq_pkg::CHAR_W-1:0]  char_q;
	logic [deq_pkg::PTR_W-1:0]   head_q, tail_q;
	logic [deq_pkg::CNT_W-1:0]   cnt_q;
	deq_pkg::status_t            status_q;

	logic                        full, empty;
	logic                        we;
	logic [deq_pkg::PTR_W-1:0]   waddr;
	logic [deq_pkg::PTR_W-1:0]   head_d, tail_d;
	logic [deq_pkg::CNT_W-1:0]   cnt_d;
	deq_pkg::status_t            status_d;
	logic [deq_pkg::CHAR_W-1:0]  rd_front, rd_back;

	assign full  = (cnt_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign empty = (cnt_q == '0);

	always_comb begin
		we       = 1'b0;
		waddr    = tail_q;
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		status_d = deq_pkg::ST_OK;
		case (func_q)
			deq_pkg::FN_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_OVERFLOW;
				end else begin
					head_d = deq_pkg::ptr_dec(head_q);
					waddr  = head_d;
					we     = 1'b1;
					cnt_d  = cnt_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::FN_PUSH_BACK: begin
				if (full) begin
					status_d = deq_pkg::ST_OVERFLOW;
				end else begin
					waddr  = tail_q;
					tail_d = deq_pkg::ptr_inc(tail_q);
					we     = 1'b1;
					cnt_d  = cnt_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::FN_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_UNDERFLOW;
				end else begin
					head_d = deq_pkg::ptr_inc(head_q);
					cnt_d  = cnt_q - deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::FN_POP_BACK: begin
				if (empty) begin
					status_d = deq_pkg::ST_UNDERFLOW;
				end else begin
					tail_d = deq_pkg::ptr_dec(tail_q);
					cnt_d  = cnt_q - deq_pkg::CNT_W'(1);
				end
			end
			default: begin
				status_d = deq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= item.func;
			char_q <= item.char_in;
		end
		if (cmd.exec) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
		end
	end

	// read happens the cycle after the write, so no read/write collision
	deq_ram #(
		.WIDTH(deq_pkg::CHAR_W),
		.DEPTH(deq_pkg::DEPTH)
	) u_ring (
		.clk     (clk),
		.we      (cmd.exec && we),
		.waddr   (waddr),
		.wdata   (char_q),
		.re      (cmd.read),
		.raddr_a (head_q),
		.raddr_b (deq_pkg::ptr_dec(tail_q)),
		.rdata_a (rd_front),
		.rdata_b (rd_back)
	);

	assign result.front_char = empty ? '0 : rd_front;
	assign result.back_char  = empty ? '0 : rd_back;
	assign result.is_empty   = empty;
	assign result.is_full    = full;
	assign result.status     = status_q;

endmodule

// ----- rtl/double_ended_queue.sv -----
// Top level of the double-ended queue of 8-bit characters.
// Depends on deq_pkg, deq_ctrl, deq_dpath (which holds deq_ram).

// A command beat is taken on a clock edge with start high and busy low. Each
// operation steps through S_EXEC, S_READ and S_DONE: the pointers and count
// update and the ring is written in S_EXEC, front and back slots are read from
// the ring's registered read port in S_READ, and the result shows with done in
// S_DONE. busy is low in S_DONE, so the next command can be taken there. done
// is high for exactly one cycle per command and the result is valid only then;
// it is not held, so the receiver must take it in that cycle. Push on a full
// queue is dropped with overflow status, pop on an empty queue is ignored with
// underflow status. No clearing pass after reset: the queue is empty and usable
// at once.
module double_ended_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  deq_pkg::deq_in_t  item,
	output logic              done,
	output deq_pkg::deq_out_t result
);
	deq_pkg::deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	deq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted beat did not start the sequence");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in flight");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_empty && result.is_full))
		else $error("queue reported empty and full at once");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == deq_pkg::ST_UNDERFLOW) |-> result.is_empty)
		else $error("underflow on a non-empty queue");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == deq_pkg::ST_OVERFLOW) |-> result.is_full)
		else $error("overflow on a non-full queue");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for double_ended_queue: directed corner cases, then
// random push/pop traffic checked against a ring-buffer prediction of the deque.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_OPS  = 1600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 12;

	// Tracks deque contents and holds the front/back views each beat should produce.
	class deque_tracker;
		logic [deq_pkg::CHAR_W-1:0] ring [deq_pkg::DEPTH];
		logic [deq_pkg::PTR_W-1:0]  head;
		logic [deq_pkg::PTR_W-1:0]  tail;
		int unsigned                fill;
		deq_pkg::deq_out_t          expected_views[$];
		int unsigned                errors;

		function new();
			head = '0;
			tail = '0;
			fill = 0;
			errors = 0;
		endfunction

		function void note_op(deq_pkg::deq_in_t beat);
			deq_pkg::deq_out_t         view;
			deq_pkg::status_t          st;
			logic [deq_pkg::PTR_W-1:0] last;
			st = deq_pkg::ST_OK;
			case (deq_pkg::func_t'(beat.func))
				deq_pkg::FN_PUSH_FRONT: begin
					if (fill == deq_pkg::DEPTH) begin
						st = deq_pkg::ST_OVERFLOW;
					end else begin
						head = deq_pkg::ptr_dec(head);
						ring[head] = beat.char_in;
						fill++;
					end
				end
				deq_pkg::FN_PUSH_BACK: begin
					if (fill == deq_pkg::DEPTH) begin
						st = deq_pkg::ST_OVERFLOW;
					end else begin
						ring[tail] = beat.char_in;
						tail = deq_pkg::ptr_inc(tail);
						fill++;
					end
				end
				deq_pkg::FN_POP_FRONT: begin
					if (fill == 0) begin
						st = deq_pkg::ST_UNDERFLOW;
					end else begin
						head = deq_pkg::ptr_inc(head);
						fill--;
					end
				end
				default: begin
					if (fill == 0) begin
						st = deq_pkg::ST_UNDERFLOW;
					end else begin
						tail = deq_pkg::ptr_dec(tail);
						fill--;
					end
				end
			endcase
			last = deq_pkg::ptr_dec(tail);
			view.front_char = (fill == 0) ? '0 : ring[head];
			view.back_char  = (fill == 0) ? '0 : ring[last];
			view.is_empty   = (fill == 0);
			view.is_full    = (fill == deq_pkg::DEPTH);
			view.status     = st;
			expected_views.push_back(view);
		endfunction

		task report_mismatch(string what, logic [deq_pkg::CHAR_W-1:0] got,
				logic [deq_pkg::CHAR_W-1:0] want);
			errors++;
			$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		endtask

		task check_result(deq_pkg::deq_out_t got);
			deq_pkg::deq_out_t want;
			if (expected_views.size() == 0) begin
				errors++;
				$display("%0t result beat with nothing outstanding", $realtime);
			end else begin
				want = expected_views.pop_front();
				if (got.front_char !== want.front_char)
					report_mismatch("front_char", got.front_char, want.front_char);
				if (got.back_char !== want.back_char)
					report_mismatch("back_char", got.back_char, want.back_char);
				if (got.is_empty !== want.is_empty)
					report_mismatch("is_empty", deq_pkg::CHAR_W'(got.is_empty),
						deq_pkg::CHAR_W'(want.is_empty));
				if (got.is_full !== want.is_full)
					report_mismatch("is_full", deq_pkg::CHAR_W'(got.is_full),
						deq_pkg::CHAR_W'(want.is_full));
				if (got.status !== want.status)
					report_mismatch("status", deq_pkg::CHAR_W'(got.status),
						deq_pkg::CHAR_W'(want.status));
			end
		endtask

		function int unsigned pending();
			return expected_views.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	deq_pkg::deq_in_t  item = '0;
	logic              done;
	deq_pkg::deq_out_t result;

	deque_tracker tracker = new();
	int unsigned  cycles = 0;
	int unsigned  burst_left = 0;

	double_ended_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// accept and result sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.note_op(item);
			if (done)
				tracker.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic deq_pkg::deq_in_t op(deq_pkg::func_t f,
			logic [deq_pkg::CHAR_W-1:0] ch);
		deq_pkg::deq_in_t b;
		b.func = f;
		b.char_in = ch;
		return b;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task send_beat(deq_pkg::deq_in_t b);
		start <= 1'b1;
		item  <= b;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// start low with junk on item, then idle for the length given by n
	task idle(int unsigned n);
		start <= 1'b0;
		item  <= deq_pkg::deq_in_t'($bits(deq_pkg::deq_in_t)'($urandom_range(0, 1023)));
		repeat (n) @(negedge clk);
	endtask

	// bursts of back-to-back beats separated by random gaps
	task pace();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0)
				idle(gap);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task push_op(deq_pkg::deq_in_t b);
		pace();
		send_beat(b);
	endtask

	initial begin
		int unsigned    push_pct;
		int unsigned    phase_left;
		deq_pkg::func_t f;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty pops, single element seen at both ends, extremes of char
		push_op(op(deq_pkg::FN_POP_FRONT, 8'h00));
		push_op(op(deq_pkg::FN_POP_BACK, 8'hFF));
		push_op(op(deq_pkg::FN_PUSH_BACK, 8'h00));
		push_op(op(deq_pkg::FN_POP_FRONT, 8'hFF));
		push_op(op(deq_pkg::FN_PUSH_FRONT, 8'hFF));
		push_op(op(deq_pkg::FN_POP_BACK, 8'h00));
		// fill to full from both ends, then overflow at each end
		for (int i = 0; i < deq_pkg::DEPTH; i++)
			push_op(op((i % 2) ? deq_pkg::FN_PUSH_FRONT : deq_pkg::FN_PUSH_BACK,
				deq_pkg::CHAR_W'(8'h55 ^ (i * 8'h1D))));
		push_op(op(deq_pkg::FN_PUSH_FRONT, 8'hAA));
		push_op(op(deq_pkg::FN_PUSH_BACK, 8'h5A));

		// random walk with push/pop bias phases so both full and empty recur
		push_pct = 50;
		phase_left = 0;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
				phase_left = $urandom_range(10, 60);
			end
			phase_left--;
			if ($urandom_range(0, 99) < push_pct)
				f = $urandom_range(0, 1) ? deq_pkg::FN_PUSH_FRONT : deq_pkg::FN_PUSH_BACK;
			else
				f = $urandom_range(0, 1) ? deq_pkg::FN_POP_FRONT : deq_pkg::FN_POP_BACK;
			push_op(op(f, deq_pkg::CHAR_W'($urandom_range(0, 255))));
		end
		idle(1);

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (tracker.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
